// ===== rtl/rsp_pkg.sv =====
// Shared types and constants of the RESP2 stream parser.
// Used by the controller, the datapath and the top level.
package rsp_pkg;

    // Result kinds
    localparam logic [3:0] K_SBYTE  = 4'd0;
    localparam logic [3:0] K_EBYTE  = 4'd1;
    localparam logic [3:0] K_BBYTE  = 4'd2;
    localparam logic [3:0] K_SEND   = 4'd3;
    localparam logic [3:0] K_EEND   = 4'd4;
    localparam logic [3:0] K_BEND   = 4'd5;
    localparam logic [3:0] K_INT    = 4'd6;
    localparam logic [3:0] K_NIL    = 4'd7;
    localparam logic [3:0] K_ARRHDR = 4'd8;
    localparam logic [3:0] K_FAULT  = 4'd9;

    // Protocol characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Number field source
    localparam logic [1:0] NUM_ZERO = 2'd0;
    localparam logic [1:0] NUM_INT  = 2'd1;
    localparam logic [1:0] NUM_MAG  = 2'd2;

    // Magnitude limits
    localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  data_byte;
        logic [63:0] number;
        logic [4:0]  nesting;
        logic        message_end;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic       acc_clr;
        logic       acc_step;
        logic       minus;
        logic       bulk_ld;
        logic       bulk_dec;
        logic       push;
        logic       pop;
        logic       dec_top;
        logic       set_end;
        logic       out_take;
        logic       wr0;
        logic       wr1;
        logic [3:0] kind0;
        logic [3:0] kind1;
        logic [7:0] data0;
        logic [7:0] data1;
        logic [1:0] num_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ovf;
        logic mag_zero;
        logic mag_one;
        logic mag_big;
        logic bulk_last;
        logic stack_full;
        logic stack_empty;
        logic top_is_one;
        logic v0;
    } t_stat;

endpackage

// ===== rtl/rsp_if.sv =====
// Stream interfaces of the RESP2 parser: raw byte requests in, results out.
// Depends on nothing.
interface rsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rsp_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic [7:0]         data_byte;
    logic signed [63:0] number;
    logic [4:0]         nesting;
    logic               message_end;
    modport source (output valid, output kind, output data_byte, output number,
                    output nesting, output message_end, input ready);
    modport sink (input valid, input kind, input data_byte, input number,
                  input nesting, input message_end, output ready);
endinterface

// ===== rtl/resp_stream_parser.sv =====
// RESP2 stream parser: one raw byte per input request, typed results out.
// Uses rsp_pkg, rsp_if, rsp_ctrl and rsp_datapath.
//
// Usage:
//   i_req carries one stream byte per request (in_byte). o_res carries
//   results: kind, data_byte, number, nesting and message_end.
//   A byte that yields no result leaves i_req ready for the next byte. A
//   byte that yields results registers the first of them for o_res; the next
//   byte is taken once all of its results have left.
//   A result that ends an element (string end, integer, nil, empty array,
//   bulk end) is held off o_res while the array count stack unwinds through
//   the arrays that this element closes (one level a cycle).
//   A stalled result holds o_res, and i_req stays not ready.
//   After a fault result, bytes are still taken but yield nothing.
//   Reset (i_rst_n low, synchronous) returns to waiting for a prefix with no
//   open array and no pending result.
module resp_stream_parser import rsp_pkg::*; #(
    parameter int MAX_DEPTH  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rsp_byte_if.sink  i_req,
    rsp_res_if.source o_res
);
    t_cmd  cmd;
    t_stat stat;
    t_res  res;

    rsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_byte      (i_req.in_byte),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_ready     (i_req.ready),
        .o_valid     (o_res.valid),
        .o_cmd       (cmd)
    );

    rsp_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_req.in_byte),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (res)
    );

    assign o_res.kind        = res.kind;
    assign o_res.data_byte   = res.data_byte;
    assign o_res.number      = res.number;
    assign o_res.nesting     = res.nesting;
    assign o_res.message_end = res.message_end;

endmodule

// ===== rtl/rsp_datapath.sv =====
// Datapath: digit accumulator, bulk counter, array count stack, result slots.
// Depends on rsp_pkg.
module rsp_datapath import rsp_pkg::*; #(
    parameter int MAX_DEPTH  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output t_res       o_res
);
    localparam int TW = $clog2(MAX_DEPTH + 1);
    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [63:0]         r_acc;
    logic [COUNT_BITS-1:0] r_bulk;
    logic [COUNT_BITS-1:0] r_stack [MAX_DEPTH];
    logic [TW-1:0]       r_top;
    logic                r_v0, r_v1;
    t_res                r_s0, r_s1;

    logic [67:0]           acc10;
    logic [63:0]           lim;
    logic [3:0]            digit;
    logic [DW-1:0]         top_idx;
    logic [COUNT_BITS-1:0] top_val;
    logic [63:0]           num_val;
    logic [4:0]            nest;

    // Next accumulator value and overflow against the signed limit
    assign digit = 4'(i_byte - CH_ZERO);
    assign acc10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {64'd0, digit};
    assign lim   = i_cmd.minus ? MAG_NEG_LIMIT : MAG_POS_LIMIT;

    assign top_idx = DW'(r_top - TW'(1));
    assign top_val = r_stack[top_idx];
    assign nest    = 5'(r_top);

    always_comb begin
        case (i_cmd.num_sel)
            NUM_INT: num_val = i_cmd.minus ? (64'd0 - r_acc) : r_acc;
            NUM_MAG: num_val = r_acc;
            default: num_val = '0;
        endcase
    end

    assign o_stat.ovf         = acc10 > {4'd0, lim};
    assign o_stat.mag_zero    = r_acc == 64'd0;
    assign o_stat.mag_one     = r_acc == 64'd1;
    assign o_stat.mag_big     = |r_acc[63:COUNT_BITS];
    assign o_stat.bulk_last   = r_bulk == COUNT_BITS'(1);
    assign o_stat.stack_full  = r_top >= TW'(MAX_DEPTH);
    assign o_stat.stack_empty = r_top == '0;
    assign o_stat.top_is_one  = top_val == COUNT_BITS'(1);
    assign o_stat.v0          = r_v0;
    assign o_res              = r_s0;

    // Accumulator and bulk counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_step) begin
            r_acc <= acc10[63:0];
        end
        if (i_cmd.bulk_ld) begin
            r_bulk <= r_acc[COUNT_BITS-1:0];
        end else if (i_cmd.bulk_dec) begin
            r_bulk <= r_bulk - COUNT_BITS'(1);
        end
    end

    // Count stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_cmd.push) begin
            r_top <= r_top + TW'(1);
        end else if (i_cmd.pop) begin
            r_top <= r_top - TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[DW'(r_top)] <= r_acc[COUNT_BITS-1:0];
        end else if (i_cmd.dec_top) begin
            r_stack[top_idx] <= top_val - COUNT_BITS'(1);
        end
    end

    // Two result slots; slot 1 only holds the byte after a lone CR
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_cmd.out_take) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end else begin
            if (i_cmd.wr0) r_v0 <= 1'b1;
            if (i_cmd.wr1) r_v1 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_take) begin
            r_s0 <= r_s1;
        end else if (i_cmd.wr0) begin
            r_s0 <= '{kind: i_cmd.kind0, data_byte: i_cmd.data0, number: num_val,
                      nesting: nest, message_end: 1'b0};
        end else if (i_cmd.set_end) begin
            r_s0.message_end <= 1'b1;
        end
        if (i_cmd.wr1) begin
            r_s1 <= '{kind: i_cmd.kind1, data_byte: i_cmd.data1, number: 64'd0,
                      nesting: nest, message_end: 1'b0};
        end
    end

endmodule

// ===== rtl/rsp_ctrl.sv =====
// Controller: parse phase machine and array unwind sequencer.
// Depends on rsp_pkg; drives rsp_datapath through t_cmd.
module rsp_ctrl import rsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_ready,
    output logic       o_valid,
    output t_cmd       o_cmd
);
    localparam logic [3:0] PH_PREFIX    = 4'd0;
    localparam logic [3:0] PH_SIMPLE    = 4'd1;
    localparam logic [3:0] PH_ERRSTR    = 4'd2;
    localparam logic [3:0] PH_NUM_INT   = 4'd3;
    localparam logic [3:0] PH_NUM_BULK  = 4'd4;
    localparam logic [3:0] PH_NUM_ARR   = 4'd5;
    localparam logic [3:0] PH_LF_INT    = 4'd6;
    localparam logic [3:0] PH_LF_BULK   = 4'd7;
    localparam logic [3:0] PH_LF_ARR    = 4'd8;
    localparam logic [3:0] PH_BULK_DATA = 4'd9;
    localparam logic [3:0] PH_SKIP1     = 4'd10;
    localparam logic [3:0] PH_SKIP2     = 4'd11;
    localparam logic [3:0] PH_FAULT     = 4'd12;

    localparam logic CS_RUN    = 1'b0;
    localparam logic CS_UNWIND = 1'b1;

    logic [3:0] r_phase, n_phase;
    logic       r_cs, n_cs;
    logic       r_minus, n_minus;
    logic       r_digit, n_digit;
    logic       r_crp, n_crp;
    logic       accept;
    logic       is_digit;
    logic       str_err;

    assign o_ready  = (r_cs == CS_RUN) && !i_stat.v0;
    assign o_valid  = (r_cs == CS_RUN) && i_stat.v0;
    assign accept   = i_valid && o_ready;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign str_err  = r_phase == PH_ERRSTR;

    always_comb begin
        n_phase = r_phase;
        n_cs    = r_cs;
        n_minus = r_minus;
        n_digit = r_digit;
        n_crp   = r_crp;
        o_cmd   = '0;
        o_cmd.minus    = r_minus;
        o_cmd.out_take = o_valid && i_out_ready;

        // Unwind: count one element off the open arrays, one level a cycle
        if (r_cs == CS_UNWIND) begin
            if (i_stat.stack_empty) begin
                o_cmd.set_end = 1'b1;
                n_cs = CS_RUN;
            end else if (i_stat.top_is_one) begin
                o_cmd.pop = 1'b1;
            end else begin
                o_cmd.dec_top = 1'b1;
                n_cs = CS_RUN;
            end
        end else if (accept) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    n_crp = 1'b0;
                    n_minus = 1'b0;
                    n_digit = 1'b0;
                    unique case (i_byte)
                        CH_PLUS:   n_phase = PH_SIMPLE;
                        CH_MINUS:  n_phase = PH_ERRSTR;
                        CH_COLON: begin
                            n_phase = PH_NUM_INT;
                            o_cmd.acc_clr = 1'b1;
                        end
                        CH_DOLLAR: begin
                            n_phase = PH_NUM_BULK;
                            o_cmd.acc_clr = 1'b1;
                        end
                        CH_STAR: begin
                            n_phase = PH_NUM_ARR;
                            o_cmd.acc_clr = 1'b1;
                        end
                        default: begin
                            o_cmd.wr0 = 1'b1;
                            o_cmd.kind0 = K_FAULT;
                            n_phase = PH_FAULT;
                        end
                    endcase
                end
                PH_SIMPLE, PH_ERRSTR: begin
                    if (r_crp && i_byte == CH_LF) begin
                        n_crp = 1'b0;
                        n_phase = PH_PREFIX;
                        o_cmd.wr0 = 1'b1;
                        o_cmd.kind0 = str_err ? K_EEND : K_SEND;
                        n_cs = CS_UNWIND;
                    end else if (r_crp) begin
                        // lone CR goes out as data, then this byte unless it is a CR
                        o_cmd.wr0 = 1'b1;
                        o_cmd.kind0 = str_err ? K_EBYTE : K_SBYTE;
                        o_cmd.data0 = CH_CR;
                        if (i_byte == CH_CR) begin
                            n_crp = 1'b1;
                        end else begin
                            n_crp = 1'b0;
                            o_cmd.wr1 = 1'b1;
                            o_cmd.kind1 = str_err ? K_EBYTE : K_SBYTE;
                            o_cmd.data1 = i_byte;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_crp = 1'b1;
                    end else begin
                        o_cmd.wr0 = 1'b1;
                        o_cmd.kind0 = str_err ? K_EBYTE : K_SBYTE;
                        o_cmd.data0 = i_byte;
                    end
                end
                PH_NUM_INT, PH_NUM_BULK, PH_NUM_ARR: begin
                    if (i_byte == CH_CR && r_digit) begin
                        n_phase = r_phase + (PH_LF_INT - PH_NUM_INT);
                    end else if (i_byte == CH_MINUS && !r_minus && !r_digit) begin
                        n_minus = 1'b1;
                    end else if (is_digit && !i_stat.ovf) begin
                        o_cmd.acc_step = 1'b1;
                        n_digit = 1'b1;
                    end else begin
                        o_cmd.wr0 = 1'b1;
                        o_cmd.kind0 = K_FAULT;
                        n_phase = PH_FAULT;
                    end
                end
                PH_LF_INT, PH_LF_BULK, PH_LF_ARR: begin
                    n_phase = PH_PREFIX;
                    o_cmd.wr0 = 1'b1;
                    if (i_byte != CH_LF) begin
                        o_cmd.kind0 = K_FAULT;
                        n_phase = PH_FAULT;
                    end else if (r_phase == PH_LF_INT) begin
                        o_cmd.kind0 = K_INT;
                        o_cmd.num_sel = NUM_INT;
                        n_cs = CS_UNWIND;
                    end else if (r_minus && i_stat.mag_one) begin
                        o_cmd.kind0 = K_NIL;
                        n_cs = CS_UNWIND;
                    end else if ((r_minus && !i_stat.mag_zero) || i_stat.mag_big) begin
                        o_cmd.kind0 = K_FAULT;
                        n_phase = PH_FAULT;
                    end else if (r_phase == PH_LF_BULK) begin
                        o_cmd.wr0 = 1'b0;
                        o_cmd.bulk_ld = 1'b1;
                        n_phase = i_stat.mag_zero ? PH_SKIP1 : PH_BULK_DATA;
                    end else if (i_stat.mag_zero) begin
                        o_cmd.kind0 = K_ARRHDR;
                        o_cmd.num_sel = NUM_MAG;
                        n_cs = CS_UNWIND;
                    end else if (i_stat.stack_full) begin
                        o_cmd.kind0 = K_FAULT;
                        n_phase = PH_FAULT;
                    end else begin
                        o_cmd.kind0 = K_ARRHDR;
                        o_cmd.num_sel = NUM_MAG;
                        o_cmd.push = 1'b1;
                    end
                end
                PH_BULK_DATA: begin
                    o_cmd.wr0 = 1'b1;
                    o_cmd.kind0 = K_BBYTE;
                    o_cmd.data0 = i_byte;
                    o_cmd.bulk_dec = 1'b1;
                    if (i_stat.bulk_last) n_phase = PH_SKIP1;
                end
                PH_SKIP1: n_phase = PH_SKIP2;
                PH_SKIP2: begin
                    n_phase = PH_PREFIX;
                    o_cmd.wr0 = 1'b1;
                    o_cmd.kind0 = K_BEND;
                    n_cs = CS_UNWIND;
                end
                default: n_phase = PH_FAULT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_cs    <= CS_RUN;
            r_minus <= 1'b0;
            r_digit <= 1'b0;
            r_crp   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cs    <= n_cs;
            r_minus <= n_minus;
            r_digit <= n_digit;
            r_crp   <= n_crp;
        end
    end

endmodule
